>>> design/mlpq_pkg.sv
// mlpq_pkg: payload structs, command codes and level constants for the
// multilevel priority task queue. No dependencies.
package mlpq_pkg;

    // Field widths fixed by the transaction format
    localparam int FUNC_W  = 4;
    localparam int ID_W    = 16;
    localparam int LEVEL_W = 2;
    localparam int COUNT_W = 6;

    // Priority levels
    localparam int LEVELS  = 4;
    localparam int NUM_LVL = 2 ** LEVEL_W;
    localparam logic [LEVEL_W-1:0] LVL_TOP =
        LEVEL_W'((LEVELS > NUM_LVL) ? NUM_LVL - 1 : LEVELS - 1);

    // Default depth of the slot store
    localparam int CAPACITY = 32;

    // Command codes
    localparam logic [FUNC_W-1:0] FN_ENQ    = 4'd0;
    localparam logic [FUNC_W-1:0] FN_DEQ    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK   = 4'd2;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 4'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 4'd4;
    localparam logic [FUNC_W-1:0] FN_PROMO  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_DEMO   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 4'd8;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    task_id;
        logic [ID_W-1:0]    session_id;
        logic [LEVEL_W-1:0] level;
    } cmd_t;

    typedef struct packed {
        logic               entry_valid;
        logic [ID_W-1:0]    out_task_id;
        logic [ID_W-1:0]    out_session_id;
        logic [LEVEL_W-1:0] out_level;
        logic               overflow;
        logic [COUNT_W-1:0] total_count;
        logic [COUNT_W-1:0] level_count;
    } rsp_t;

    // Identity half of a slot
    typedef struct packed {
        logic [ID_W-1:0] task_id;
        logic [ID_W-1:0] session_id;
    } slot_id_t;

endpackage

>>> design/multilevel_priority_task_queue.sv
// multilevel_priority_task_queue: slot store with per-level FIFO ranks.
// Depends on mlpq_pkg.
//
// Commands are handled one at a time. Task ids, sessions, levels and FIFO
// ranks live in two single-port-read memories; valid bits and per-level
// counts are flops. Each command runs as a series of passes, a pass being
// a sweep over all CAPACITY slots that reads one slot per cycle and writes
// it back updated the next cycle, with a planning state before each pass
// and a done state that posts the result. Lookup and peek take one pass,
// enqueue, dequeue, update and remove up to two. Promote and demote take
// one pass per moved task plus one per level searched. Clear, unused codes
// and dequeue or peek on an empty queue run no pass. The next command is
// accepted while a result waits in the output register. No clearing pass
// after reset.
module multilevel_priority_task_queue #(
    parameter int CAPACITY = mlpq_pkg::CAPACITY
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mlpq_pkg::cmd_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mlpq_pkg::rsp_t  m_data
);

    localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IDX_W  = RANK_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LV_W   = mlpq_pkg::LEVEL_W;
    localparam int LR_W   = LV_W + RANK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PLAN = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        SR_NONE,
        SR_TASK,
        SR_HEAD,
        SR_SES
    } srch_t;

    // Slot memories
    mlpq_pkg::slot_id_t mem_id [CAPACITY];
    logic [LR_W-1:0]    mem_lr [CAPACITY];

    state_t state_reg, state_next;
    mlpq_pkg::cmd_t cmd_reg, cmd_next;
    logic [LV_W-1:0] lvl_reg, lvl_next;
    logic [1:0] phase_reg, phase_next;
    logic [LV_W-1:0] cur_l_reg, cur_l_next;
    logic last_srch_reg, last_srch_next;

    // Pass parameters
    logic dec_en_reg, dec_en_next;
    logic [LV_W-1:0] dec_lvl_reg, dec_lvl_next;
    logic [RANK_W-1:0] dec_rank_reg, dec_rank_next;
    logic mov_en_reg, mov_en_next;
    logic [IDX_W-1:0] mov_slot_reg, mov_slot_next;
    logic mov_set_reg, mov_set_next;
    logic [LV_W-1:0] mov_lvl_reg, mov_lvl_next;
    logic [RANK_W-1:0] mov_rank_reg, mov_rank_next;
    logic mov_wrid_reg, mov_wrid_next;
    srch_t srch_reg, srch_next;
    logic [LV_W-1:0] srch_lvl_reg, srch_lvl_next;

    // Sweep pipeline
    logic rd_act_reg, rd_act_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic p_val_reg;
    logic [IDX_W-1:0] p_idx_reg;
    mlpq_pkg::slot_id_t id_rd;
    logic [LR_W-1:0] lr_rd;

    // Search results
    logic fnd_reg, fnd_next;
    logic [IDX_W-1:0] fnd_idx_reg, fnd_idx_next;
    logic [LV_W-1:0] fnd_lvl_reg, fnd_lvl_next;
    logic [RANK_W-1:0] fnd_rank_reg, fnd_rank_next;
    logic [mlpq_pkg::ID_W-1:0] fnd_task_reg, fnd_task_next;
    logic [mlpq_pkg::ID_W-1:0] fnd_ses_reg, fnd_ses_next;
    logic free_fnd_reg, free_fnd_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // Occupancy
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] cnt_reg [mlpq_pkg::NUM_LVL];
    logic [CNT_W-1:0] cnt_next [mlpq_pkg::NUM_LVL];
    logic [CNT_W-1:0] total_reg, total_next;
    logic ovf_reg, ovf_next;

    logic m_valid_reg, m_valid_next;
    mlpq_pkg::rsp_t m_data_reg, m_data_next;

    // Slot processing outputs
    logic wr_lr;
    logic [LR_W-1:0] lr_wdata;
    logic wr_id;
    mlpq_pkg::slot_id_t id_wdata;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Memory read and write-back
    always_ff @(posedge aclk) begin
        if (rd_act_reg) begin
            id_rd <= mem_id[rd_idx_reg];
            lr_rd <= mem_lr[rd_idx_reg];
        end
        if (wr_lr) begin
            mem_lr[p_idx_reg] <= lr_wdata;
        end
        if (wr_id) begin
            mem_id[p_idx_reg] <= id_wdata;
        end
    end

    // Control and sweep processing
    always_comb begin
        logic best_ok;
        logic [LV_W-1:0] best_lvl;
        logic launch;
        logic finish;
        logic ln_dec_en;
        logic [LV_W-1:0] ln_dec_lvl;
        logic [RANK_W-1:0] ln_dec_rank;
        logic ln_mov_en;
        logic [IDX_W-1:0] ln_mov_slot;
        logic ln_mov_set;
        logic [LV_W-1:0] ln_mov_lvl;
        logic ln_mov_wrid;
        srch_t ln_srch;
        logic [LV_W-1:0] ln_srch_lvl;
        logic elig;
        logic is_mov;
        logic cur_v;
        logic [LV_W-1:0] cur_lvl;
        logic [RANK_W-1:0] cur_rank;
        logic new_v;
        logic [LV_W-1:0] new_lvl;
        logic [RANK_W-1:0] new_rank;
        mlpq_pkg::slot_id_t new_id;
        logic hit;
        logic ret;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lvl_next       = lvl_reg;
        phase_next     = phase_reg;
        cur_l_next     = cur_l_reg;
        last_srch_next = last_srch_reg;
        dec_en_next    = dec_en_reg;
        dec_lvl_next   = dec_lvl_reg;
        dec_rank_next  = dec_rank_reg;
        mov_en_next    = mov_en_reg;
        mov_slot_next  = mov_slot_reg;
        mov_set_next   = mov_set_reg;
        mov_lvl_next   = mov_lvl_reg;
        mov_rank_next  = mov_rank_reg;
        mov_wrid_next  = mov_wrid_reg;
        srch_next      = srch_reg;
        srch_lvl_next  = srch_lvl_reg;
        rd_act_next    = rd_act_reg;
        rd_idx_next    = rd_idx_reg;
        fnd_next       = fnd_reg;
        fnd_idx_next   = fnd_idx_reg;
        fnd_lvl_next   = fnd_lvl_reg;
        fnd_rank_next  = fnd_rank_reg;
        fnd_task_next  = fnd_task_reg;
        fnd_ses_next   = fnd_ses_reg;
        free_fnd_next  = free_fnd_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        launch      = 1'b0;
        finish      = 1'b0;
        ret         = 1'b0;
        ln_dec_en   = 1'b0;
        ln_dec_lvl  = fnd_lvl_reg;
        ln_dec_rank = fnd_rank_reg;
        ln_mov_en   = 1'b0;
        ln_mov_slot = fnd_idx_reg;
        ln_mov_set  = 1'b0;
        ln_mov_lvl  = lvl_reg;
        ln_mov_wrid = 1'b0;
        ln_srch     = SR_NONE;
        ln_srch_lvl = lvl_reg;

        // Best non-empty level
        best_ok  = 1'b0;
        best_lvl = '0;
        for (int i = mlpq_pkg::NUM_LVL - 1; i >= 0; i--) begin
            if (LV_W'(i) <= mlpq_pkg::LVL_TOP && cnt_reg[i] != '0) begin
                best_ok  = 1'b1;
                best_lvl = LV_W'(i);
            end
        end

        elig = (cmd_reg.func == mlpq_pkg::FN_PROMO) ? (cur_l_reg > lvl_reg)
                                                    : (cur_l_reg < lvl_reg);

        // Result register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Per-slot update during a sweep
        cur_v    = valid_reg[p_idx_reg];
        cur_lvl  = lr_rd[LR_W-1 -: LV_W];
        cur_rank = lr_rd[RANK_W-1:0];
        is_mov   = mov_en_reg && (p_idx_reg == mov_slot_reg);
        new_v    = cur_v;
        new_lvl  = cur_lvl;
        new_rank = cur_rank;
        new_id   = id_rd;
        if (dec_en_reg && cur_v && cur_lvl == dec_lvl_reg && cur_rank > dec_rank_reg) begin
            new_rank = cur_rank - RANK_W'(1);
        end
        if (is_mov) begin
            new_v    = mov_set_reg;
            new_lvl  = mov_lvl_reg;
            new_rank = mov_rank_reg;
            if (mov_wrid_reg) begin
                new_id.task_id    = cmd_reg.task_id;
                new_id.session_id = cmd_reg.session_id;
            end
        end
        wr_lr    = p_val_reg;
        lr_wdata = {new_lvl, new_rank};
        wr_id    = p_val_reg && is_mov && mov_wrid_reg;
        id_wdata = new_id;

        case (srch_reg)
            SR_TASK: hit = new_v && new_id.task_id == cmd_reg.task_id;
            SR_HEAD: hit = new_v && new_lvl == srch_lvl_reg && new_rank == '0;
            SR_SES:  hit = new_v && new_lvl == srch_lvl_reg
                           && new_id.session_id == cmd_reg.session_id
                           && (!fnd_reg || new_rank < fnd_rank_reg);
            default: hit = 1'b0;
        endcase

        if (p_val_reg) begin
            valid_next[p_idx_reg] = new_v;
            if (hit) begin
                fnd_next      = 1'b1;
                fnd_idx_next  = p_idx_reg;
                fnd_lvl_next  = new_lvl;
                fnd_rank_next = new_rank;
                fnd_task_next = new_id.task_id;
                fnd_ses_next  = new_id.session_id;
            end
            if (!cur_v && !free_fnd_reg) begin
                free_fnd_next = 1'b1;
                free_idx_next = p_idx_reg;
            end
        end

        // Read address sequencing
        if (rd_act_reg) begin
            if (rd_idx_reg == LAST_IDX) begin
                rd_act_next = 1'b0;
            end else begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next       = s_data;
                    lvl_next       = (s_data.level > mlpq_pkg::LVL_TOP) ? mlpq_pkg::LVL_TOP
                                                                        : s_data.level;
                    phase_next     = '0;
                    cur_l_next     = '0;
                    last_srch_next = 1'b0;
                    fnd_next       = 1'b0;
                    ovf_next       = 1'b0;
                    state_next     = ST_PLAN;
                end
            end
            ST_PLAN: begin
                last_srch_next = 1'b0;
                case (cmd_reg.func)
                    mlpq_pkg::FN_ENQ: begin
                        if (phase_reg == 2'd0) begin
                            launch  = 1'b1;
                            ln_srch = SR_TASK;
                        end else if (phase_reg == 2'd1) begin
                            if (fnd_reg) begin
                                launch      = 1'b1;
                                ln_dec_en   = 1'b1;
                                ln_mov_en   = 1'b1;
                                ln_mov_set  = 1'b1;
                                ln_mov_wrid = 1'b1;
                            end else if (free_fnd_reg) begin
                                launch      = 1'b1;
                                ln_mov_en   = 1'b1;
                                ln_mov_slot = free_idx_reg;
                                ln_mov_set  = 1'b1;
                                ln_mov_wrid = 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                                finish   = 1'b1;
                            end
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    mlpq_pkg::FN_DEQ, mlpq_pkg::FN_PEEK: begin
                        if (phase_reg == 2'd0 && best_ok) begin
                            launch      = 1'b1;
                            ln_srch     = SR_HEAD;
                            ln_srch_lvl = best_lvl;
                        end else if (phase_reg == 2'd1 && fnd_reg
                                     && cmd_reg.func == mlpq_pkg::FN_DEQ) begin
                            launch    = 1'b1;
                            ln_dec_en = 1'b1;
                            ln_mov_en = 1'b1;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    mlpq_pkg::FN_UPDATE: begin
                        if (phase_reg == 2'd0) begin
                            launch  = 1'b1;
                            ln_srch = SR_TASK;
                        end else if (phase_reg == 2'd1 && fnd_reg && fnd_lvl_reg != lvl_reg) begin
                            launch     = 1'b1;
                            ln_dec_en  = 1'b1;
                            ln_mov_en  = 1'b1;
                            ln_mov_set = 1'b1;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    mlpq_pkg::FN_REMOVE: begin
                        if (phase_reg == 2'd0) begin
                            launch  = 1'b1;
                            ln_srch = SR_TASK;
                        end else if (phase_reg == 2'd1 && fnd_reg) begin
                            launch    = 1'b1;
                            ln_dec_en = 1'b1;
                            ln_mov_en = 1'b1;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    mlpq_pkg::FN_LOOKUP: begin
                        if (phase_reg == 2'd0) begin
                            launch  = 1'b1;
                            ln_srch = SR_TASK;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    mlpq_pkg::FN_PROMO, mlpq_pkg::FN_DEMO: begin
                        // Move the found task and look for the next one at the same level
                        if (fnd_reg) begin
                            launch      = 1'b1;
                            ln_dec_en   = 1'b1;
                            ln_mov_en   = 1'b1;
                            ln_mov_set  = 1'b1;
                            ln_srch     = SR_SES;
                            ln_srch_lvl = cur_l_reg;
                        end else if (elig && !last_srch_reg) begin
                            launch      = 1'b1;
                            ln_srch     = SR_SES;
                            ln_srch_lvl = cur_l_reg;
                        end else if (cur_l_reg == mlpq_pkg::LVL_TOP) begin
                            finish = 1'b1;
                        end else begin
                            cur_l_next = cur_l_reg + LV_W'(1);
                        end
                    end
                    mlpq_pkg::FN_CLEAR: begin
                        valid_next = '0;
                        for (int i = 0; i < mlpq_pkg::NUM_LVL; i++) begin
                            cnt_next[i] = '0;
                        end
                        total_next = '0;
                        finish     = 1'b1;
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            ST_SCAN: begin
                if (p_val_reg && p_idx_reg == LAST_IDX) begin
                    state_next = ST_PLAN;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    ret = fnd_reg && (cmd_reg.func == mlpq_pkg::FN_DEQ
                                      || cmd_reg.func == mlpq_pkg::FN_PEEK
                                      || cmd_reg.func == mlpq_pkg::FN_LOOKUP);
                    m_data_next.entry_valid    = ret;
                    m_data_next.out_task_id    = ret ? fnd_task_reg : '0;
                    m_data_next.out_session_id = ret ? fnd_ses_reg : '0;
                    m_data_next.out_level      = ret ? fnd_lvl_reg : '0;
                    m_data_next.overflow       = ovf_reg;
                    m_data_next.total_count    = mlpq_pkg::COUNT_W'(total_reg);
                    m_data_next.level_count    = mlpq_pkg::COUNT_W'(cnt_reg[lvl_reg]);
                    m_valid_next               = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Start a sweep: latch its parameters and book the count changes
        if (launch) begin
            state_next     = ST_SCAN;
            phase_next     = phase_reg + 2'd1;
            rd_act_next    = 1'b1;
            rd_idx_next    = '0;
            last_srch_next = (ln_srch != SR_NONE);
            dec_en_next    = ln_dec_en;
            dec_lvl_next   = ln_dec_lvl;
            dec_rank_next  = ln_dec_rank;
            mov_en_next    = ln_mov_en;
            mov_slot_next  = ln_mov_slot;
            mov_set_next   = ln_mov_set;
            mov_lvl_next   = ln_mov_lvl;
            mov_wrid_next  = ln_mov_wrid;
            mov_rank_next  = RANK_W'(cnt_reg[ln_mov_lvl]
                             - ((ln_dec_en && ln_dec_lvl == ln_mov_lvl) ? CNT_W'(1) : CNT_W'(0)));
            srch_next      = ln_srch;
            srch_lvl_next  = ln_srch_lvl;
            if (ln_srch != SR_NONE) begin
                fnd_next      = 1'b0;
                free_fnd_next = 1'b0;
            end
            for (int i = 0; i < mlpq_pkg::NUM_LVL; i++) begin
                if (ln_dec_en && ln_dec_lvl == LV_W'(i)) begin
                    cnt_next[i] = cnt_next[i] - CNT_W'(1);
                end
                if (ln_mov_set && ln_mov_lvl == LV_W'(i)) begin
                    cnt_next[i] = cnt_next[i] + CNT_W'(1);
                end
            end
            if (ln_dec_en && !ln_mov_set) begin
                total_next = total_reg - CNT_W'(1);
            end else if (!ln_dec_en && ln_mov_set) begin
                total_next = total_reg + CNT_W'(1);
            end
        end

        if (finish) begin
            state_next = ST_DONE;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_act_reg    <= 1'b0;
            p_val_reg     <= 1'b0;
            valid_reg     <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            fnd_reg       <= 1'b0;
            free_fnd_reg  <= 1'b0;
            last_srch_reg <= 1'b0;
            for (int i = 0; i < mlpq_pkg::NUM_LVL; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            rd_act_reg    <= rd_act_next;
            p_val_reg     <= rd_act_reg;
            valid_reg     <= valid_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
            fnd_reg       <= fnd_next;
            free_fnd_reg  <= free_fnd_next;
            last_srch_reg <= last_srch_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload and pass-parameter registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        lvl_reg       <= lvl_next;
        phase_reg     <= phase_next;
        cur_l_reg     <= cur_l_next;
        dec_en_reg    <= dec_en_next;
        dec_lvl_reg   <= dec_lvl_next;
        dec_rank_reg  <= dec_rank_next;
        mov_en_reg    <= mov_en_next;
        mov_slot_reg  <= mov_slot_next;
        mov_set_reg   <= mov_set_next;
        mov_lvl_reg   <= mov_lvl_next;
        mov_rank_reg  <= mov_rank_next;
        mov_wrid_reg  <= mov_wrid_next;
        srch_reg      <= srch_next;
        srch_lvl_reg  <= srch_lvl_next;
        rd_idx_reg    <= rd_idx_next;
        p_idx_reg     <= rd_idx_reg;
        fnd_idx_reg   <= fnd_idx_next;
        fnd_lvl_reg   <= fnd_lvl_next;
        fnd_rank_reg  <= fnd_rank_next;
        fnd_task_reg  <= fnd_task_next;
        fnd_ses_reg   <= fnd_ses_next;
        free_idx_reg  <= free_idx_next;
        ovf_reg       <= ovf_next;
        m_data_reg    <= m_data_next;
    end

    // Occupancy bookkeeping stays consistent
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(CAPACITY))
        else $error("queued count exceeds capacity");

    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE)
        |-> ($countones(valid_reg) == int'(total_reg)))
        else $error("valid bits disagree with queued count");

    a_level_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W + 2)'(cnt_reg[0]) + (CNT_W + 2)'(cnt_reg[1]) + (CNT_W + 2)'(cnt_reg[2])
        + (CNT_W + 2)'(cnt_reg[3]) == (CNT_W + 2)'(total_reg))
        else $error("level counts disagree with queued count");

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench for multilevel_priority_task_queue.
// Depends on mlpq_pkg and the block; predicts each response from a local queue model.
`timescale 1ns / 100ps

module tb_top;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    mlpq_pkg::cmd_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    mlpq_pkg::rsp_t m_data;

    multilevel_priority_task_queue DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Local copy of the queue: slots with level and FIFO rank
    bit          q_vld [mlpq_pkg::CAPACITY];
    logic [15:0] q_tid [mlpq_pkg::CAPACITY];
    logic [15:0] q_sid [mlpq_pkg::CAPACITY];
    logic [1:0]  q_lvl [mlpq_pkg::CAPACITY];
    int          q_rank [mlpq_pkg::CAPACITY];
    int          q_total;

    mlpq_pkg::rsp_t expected_rsp[$];
    int   error_count = 0;
    bit   rx_idle_on = 1'b1;
    bit   tx_idle_on = 1'b1;
    int   rx_hold = 0;
    int   rx_long_req = 0;
    int   rx_long_seen = 0;

    function automatic int lvl_count(input logic [1:0] l);
        int n;
        n = 0;
        for (int s = 0; s < mlpq_pkg::CAPACITY; s++)
            if (q_vld[s] && q_lvl[s] == l) n++;
        return n;
    endfunction

    function automatic int find_tid(input logic [15:0] t);
        for (int s = 0; s < mlpq_pkg::CAPACITY; s++)
            if (q_vld[s] && q_tid[s] == t) return s;
        return -1;
    endfunction

    function automatic void unlink(input int s);
        q_vld[s] = 1'b0;
        for (int k = 0; k < mlpq_pkg::CAPACITY; k++)
            if (q_vld[k] && q_lvl[k] == q_lvl[s] && q_rank[k] > q_rank[s]) q_rank[k]--;
        if (q_total > 0) q_total--;
    endfunction

    function automatic void append(input int s, input logic [1:0] l);
        q_rank[s] = lvl_count(l);
        q_lvl[s] = l;
        q_vld[s] = 1'b1;
        q_total++;
    endfunction

    function automatic int head_of(input logic [1:0] l, input bit by_ses, input logic [15:0] ses);
        int b;
        b = -1;
        for (int s = 0; s < mlpq_pkg::CAPACITY; s++) begin
            if (!q_vld[s] || q_lvl[s] != l) continue;
            if (by_ses && q_sid[s] != ses) continue;
            if (b < 0 || q_rank[s] < q_rank[b]) b = s;
        end
        return b;
    endfunction

    // Apply one command to the local queue and return its response
    function automatic mlpq_pkg::rsp_t predict_queue(input mlpq_pkg::cmd_t c);
        mlpq_pkg::rsp_t r;
        int s, sel;
        logic [1:0] lv;
        r = '0;
        sel = -1;
        lv = (c.level > mlpq_pkg::LVL_TOP) ? mlpq_pkg::LVL_TOP : c.level;
        case (c.func)
            mlpq_pkg::FN_ENQ: begin
                s = find_tid(c.task_id);
                if (s >= 0) unlink(s);
                else for (int k = mlpq_pkg::CAPACITY - 1; k >= 0; k--) if (!q_vld[k]) s = k;
                if (s < 0) r.overflow = 1'b1;
                else begin
                    q_tid[s] = c.task_id;
                    q_sid[s] = c.session_id;
                    append(s, lv);
                end
            end
            mlpq_pkg::FN_DEQ, mlpq_pkg::FN_PEEK: begin
                for (int l = 0; l < mlpq_pkg::LEVELS && sel < 0; l++)
                    sel = head_of(2'(l), 1'b0, 16'h0);
                if (sel >= 0 && c.func == mlpq_pkg::FN_DEQ) unlink(sel);
            end
            mlpq_pkg::FN_UPDATE: begin
                s = find_tid(c.task_id);
                if (s >= 0 && q_lvl[s] != lv) begin
                    unlink(s);
                    append(s, lv);
                end
            end
            mlpq_pkg::FN_REMOVE: begin
                s = find_tid(c.task_id);
                if (s >= 0) unlink(s);
            end
            mlpq_pkg::FN_PROMO, mlpq_pkg::FN_DEMO: begin
                for (int l = 0; l < mlpq_pkg::LEVELS; l++) begin
                    if ((c.func == mlpq_pkg::FN_PROMO) ? !(l > int'(lv)) : !(l < int'(lv)))
                        continue;
                    s = head_of(2'(l), 1'b1, c.session_id);
                    while (s >= 0) begin
                        unlink(s);
                        append(s, lv);
                        s = head_of(2'(l), 1'b1, c.session_id);
                    end
                end
            end
            mlpq_pkg::FN_CLEAR: begin
                foreach (q_vld[k]) q_vld[k] = 1'b0;
                q_total = 0;
            end
            mlpq_pkg::FN_LOOKUP: sel = find_tid(c.task_id);
            default: ;
        endcase
        if (sel >= 0) begin
            r.entry_valid = 1'b1;
            r.out_task_id = q_tid[sel];
            r.out_session_id = q_sid[sel];
            r.out_level = q_lvl[sel];
        end
        r.total_count = q_total[5:0];
        r.level_count = 6'(lvl_count(lv));
        return r;
    endfunction

    // Send one command transaction; idles a random burst first when enabled.
    // Valid stays high after acceptance until the next send or a drain wait.
    task automatic send_cmd(input mlpq_pkg::cmd_t c);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_rsp.push_back(predict_queue(c));
    endtask

    function automatic mlpq_pkg::cmd_t mk(input logic [3:0] f, input logic [15:0] t,
                                          input logic [15:0] ses, input logic [1:0] l);
        mlpq_pkg::cmd_t c;
        c.func = f; c.task_id = t; c.session_id = ses; c.level = l;
        return c;
    endfunction

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_rsp.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // Receiver: random stalls, or a long hold when one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
            rx_long_seen <= rx_long_req;
        end else if (rx_long_req != rx_long_seen) begin
            rx_long_seen <= rx_long_req;
            rx_hold <= 300;
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_hold <= $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else m_ready <= 1'b1;
    end

    // Response checker
    always @(posedge aclk) begin
        mlpq_pkg::rsp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected response %h", $time, m_data);
                error_count++;
            end else begin
                e = expected_rsp.pop_front();
                if (m_data.entry_valid !== e.entry_valid ||
                    m_data.out_task_id !== e.out_task_id ||
                    m_data.out_session_id !== e.out_session_id ||
                    m_data.out_level !== e.out_level ||
                    m_data.overflow !== e.overflow ||
                    m_data.total_count !== e.total_count ||
                    m_data.level_count !== e.level_count) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, m_data);
                    error_count++;
                end
            end
        end
    end

    // Directed: edge values, every command, empty and full cases
    task automatic test_directed();
        send_cmd(mk(mlpq_pkg::FN_DEQ, 16'h0, 16'h0, 2'd0));
        send_cmd(mk(mlpq_pkg::FN_PEEK, 16'hFFFF, 16'hFFFF, 2'd3));
        send_cmd(mk(mlpq_pkg::FN_LOOKUP, 16'h1234, 16'h0, 2'd1));
        send_cmd(mk(mlpq_pkg::FN_ENQ, 16'hFFFF, 16'hFFFF, 2'd3));
        send_cmd(mk(mlpq_pkg::FN_ENQ, 16'h0000, 16'h0000, 2'd0));
        send_cmd(mk(mlpq_pkg::FN_ENQ, 16'h0001, 16'hFFFF, 2'd2));
        send_cmd(mk(mlpq_pkg::FN_ENQ, 16'h0000, 16'h5555, 2'd1));
        send_cmd(mk(mlpq_pkg::FN_UPDATE, 16'hFFFF, 16'h0, 2'd3));
        send_cmd(mk(mlpq_pkg::FN_UPDATE, 16'hFFFF, 16'h0, 2'd0));
        send_cmd(mk(mlpq_pkg::FN_UPDATE, 16'hAAAA, 16'h0, 2'd1));
        send_cmd(mk(mlpq_pkg::FN_PROMO, 16'h0, 16'hFFFF, 2'd1));
        send_cmd(mk(mlpq_pkg::FN_DEMO, 16'h0, 16'hFFFF, 2'd3));
        send_cmd(mk(mlpq_pkg::FN_LOOKUP, 16'h0001, 16'h0, 2'd3));
        send_cmd(mk(mlpq_pkg::FN_PEEK, 16'h0, 16'h0, 2'd0));
        send_cmd(mk(mlpq_pkg::FN_REMOVE, 16'h0000, 16'h0, 2'd1));
        send_cmd(mk(mlpq_pkg::FN_REMOVE, 16'h7777, 16'h0, 2'd1));
        send_cmd(mk(mlpq_pkg::FN_DEQ, 16'h0, 16'h0, 2'd3));
        send_cmd(mk(4'd9, 16'h0, 16'h0, 2'd0));
        send_cmd(mk(4'd15, 16'hFFFF, 16'hFFFF, 2'd3));
        for (int i = 0; i < mlpq_pkg::CAPACITY + 2; i++)
            send_cmd(mk(mlpq_pkg::FN_ENQ, 16'(16'h100 + i), 16'(i % 3), 2'(i)));
        send_cmd(mk(mlpq_pkg::FN_ENQ, 16'h0100, 16'h9, 2'd3));
        send_cmd(mk(mlpq_pkg::FN_CLEAR, 16'h0, 16'h0, 2'd2));
        wait_drained();
    endtask

    // Random: small id and session pools so commands hit queued tasks
    task automatic test_random(input int n);
        mlpq_pkg::cmd_t c;
        for (int i = 0; i < n; i++) begin
            c.func = ($urandom_range(0, 99) < 3) ? 4'($urandom_range(9, 15))
                   : ($urandom_range(0, 99) < 1) ? mlpq_pkg::FN_CLEAR
                   : ($urandom_range(0, 2) == 0) ? mlpq_pkg::FN_ENQ
                   : 4'($urandom_range(0, 8));
            if (c.func == mlpq_pkg::FN_CLEAR && $urandom_range(0, 3) != 0)
                c.func = mlpq_pkg::FN_ENQ;
            c.task_id = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                      : 16'($urandom_range(0, 47)) ^ {16{$urandom_range(0, 1) == 1}};
            c.session_id = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 5)) ^ {16{$urandom_range(0, 1) == 1}};
            c.level = 2'($urandom);
            send_cmd(c);
        end
    endtask

    // Receiver holds off while commands keep coming
    task automatic test_backpressure();
        rx_long_req++;
        test_random(40);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(900);
        test_backpressure();
        test_random(800);
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        test_random(150);
        wait_drained();
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_rsp.size() == 0)
            $display("multilevel_priority_task_queue test passed");
        else
            $display("multilevel_priority_task_queue test failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("multilevel_priority_task_queue test failed");
        $finish;
    end
endmodule
